// ===== hdl/stcm_pkg.sv =====
// Shared types and codes for the system timer with compare match.
// Used by stcm_core and by the top level system_timer_compare_match.
// No dependencies.
package stcm_pkg;

	// Operation codes carried in tuser.
	localparam logic [1:0] OP_TICK  = 2'd0;
	localparam logic [1:0] OP_READ  = 2'd1;
	localparam logic [1:0] OP_WRITE = 2'd2;
	localparam logic [1:0] OP_IDLE  = 2'd3;

	// Register word codes of the bus window.
	localparam logic [2:0] WORD_STATUS   = 3'd0;
	localparam logic [2:0] WORD_COUNT_LO = 3'd1;
	localparam logic [2:0] WORD_COUNT_HI = 3'd2;
	localparam logic [2:0] WORD_CMP0     = 3'd3;
	localparam logic [2:0] WORD_CMP1     = 3'd4;
	localparam logic [2:0] WORD_CMP2     = 3'd5;
	localparam logic [2:0] WORD_CMP3     = 3'd6;
	localparam logic [2:0] WORD_INVALID  = 3'd7;

	// Access status codes.
	localparam logic [1:0] ACC_OK         = 2'd0;
	localparam logic [1:0] ACC_BAD_OFFSET = 2'd1;
	localparam logic [1:0] ACC_READ_ONLY  = 2'd2;
	localparam logic [1:0] ACC_RESERVED   = 2'd3;

	// Bit positions of the match flags in the status word.
	localparam int STATUS_BIT_ONE   = 1;
	localparam int STATUS_BIT_THREE = 3;

	localparam int DATA_W    = 32;
	localparam int COUNT_W   = 64;
	localparam int NUM_CMP   = 4;
	localparam int IN_TDATA_W  = 40;
	localparam int OUT_TDATA_W = 40;

	// One input item; the operation travels in tuser, the rest in tdata.
	typedef struct packed {
		logic [1:0]        op;
		logic [2:0]        word;
		logic [DATA_W-1:0] data;
	} stcm_item_t;

	// One result item, packed so read_data sits in the lowest bits.
	typedef struct packed {
		logic [1:0]        access_status;
		logic              irq_channel_three;
		logic              irq_channel_one;
		logic [DATA_W-1:0] read_data;
	} stcm_result_t;

endpackage

// ===== hdl/system_timer_compare_match.sv =====
// Top level of the system timer with compare match: stream ports, the input
// stage and the result register around stcm_core. Depends on stcm_pkg, stcm_core.
//
//  Channel  Direction  Handshake                    Contents
//  s_axis   in         s_axis_tvalid/s_axis_tready  tuser operation, tdata word and data
//  m_axis   out        m_axis_tvalid/m_axis_tready  tdata read data, irq lines, status
//
// Every item gives exactly one result. One item is accepted per cycle unless the
// result stalls; the input register feeds combinational logic (64-bit increment,
// two 32-bit compares, read mux) into the result register.
// Reset clears the counter, match flags and compare registers, and empties both stages.
// A stalled result holds the item in the input stage, which then stops accepting.
module system_timer_compare_match (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_axis_tvalid,
	output logic                               s_axis_tready,
	// [2:0] word_index, [34:3] write_data, [39:35] zero
	input  logic [stcm_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
	// [1:0] operation
	input  logic [1:0]                         s_axis_tuser,
	output logic                               m_axis_tvalid,
	input  logic                               m_axis_tready,
	// [31:0] read_data, [32] irq_channel_one, [33] irq_channel_three,
	// [35:34] access_status, [39:36] zero
	output logic [stcm_pkg::OUT_TDATA_W-1:0]   m_axis_tdata
);
	import stcm_pkg::*;

	logic         valid_s1;
	stcm_item_t   item_s1;
	logic         out_valid_q;
	stcm_result_t out_q;
	stcm_result_t result;
	logic         advance;
	logic         in_take;

	// The input stage moves on whenever the result register is free or drains.
	assign advance       = valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;
	assign in_take       = s_axis_tvalid && s_axis_tready;

	// Input stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			item_s1.op   <= s_axis_tuser;
			item_s1.word <= s_axis_tdata[2:0];
			item_s1.data <= s_axis_tdata[DATA_W+2:3];
		end
	end

	stcm_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.step_en (advance),
		.item    (item_s1),
		.result  (result)
	);

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) out_q <= result;
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {(OUT_TDATA_W - $bits(stcm_result_t))'(0), out_q};

	// An empty input stage always takes an item.
	a_empty_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> s_axis_tready)
		else $error("input stage empty but not ready");

	// A stalled result blocks the input stage from moving on.
	a_stall_holds_s1: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !m_axis_tready |-> !advance)
		else $error("input stage advanced over a stalled result");

	// An item that moves on becomes a valid result next cycle.
	a_advance_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> out_valid_q)
		else $error("advanced item produced no result");

endmodule

// ===== hdl/stcm_core.sv =====
// Timer state (counter, match flags, compare registers) and the single-pass
// logic that turns one item into its result. Depends on stcm_pkg.
module stcm_core (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  step_en,
	input  stcm_pkg::stcm_item_t  item,
	output stcm_pkg::stcm_result_t result
);
	import stcm_pkg::*;

	logic [COUNT_W-1:0] count_q;
	logic [1:0]         flags_q;      // bit 0 channel 1, bit 1 channel 3
	logic [DATA_W-1:0]  cmp_q [NUM_CMP];

	logic [COUNT_W-1:0] count_inc;
	logic [DATA_W-1:0]  count_lo_inc;
	logic [1:0]         flags_d;
	logic [1:0]         cmp_idx;
	logic               cmp_word;
	logic               cmp_wr;
	logic [DATA_W-1:0]  status_word;
	logic [DATA_W-1:0]  rd;
	logic [1:0]         acc;

	assign count_inc    = count_q + COUNT_W'(1);
	assign count_lo_inc = count_inc[DATA_W-1:0];
	assign cmp_idx      = 2'(item.word - WORD_CMP0);
	assign cmp_word     = (item.word >= WORD_CMP0) && (item.word <= WORD_CMP3);

	// Status word shows each flag at its own bit, all other bits zero.
	always_comb begin
		status_word = '0;
		status_word[STATUS_BIT_ONE]   = flags_q[0];
		status_word[STATUS_BIT_THREE] = flags_q[1];
	end

	// Decode the item: read data, access status, next flags.
	always_comb begin
		rd      = '0;
		acc     = ACC_OK;
		flags_d = flags_q;
		cmp_wr  = 1'b0;
		unique case (item.op)
			OP_TICK: begin
				if (count_lo_inc == cmp_q[1]) flags_d[0] = 1'b1;
				if (count_lo_inc == cmp_q[3]) flags_d[1] = 1'b1;
			end
			OP_READ: begin
				if (item.word == WORD_STATUS) begin
					rd = status_word;
				end else if (item.word == WORD_COUNT_LO) begin
					rd = count_q[DATA_W-1:0];
				end else if (item.word == WORD_COUNT_HI) begin
					rd = count_q[COUNT_W-1:DATA_W];
				end else if (cmp_word) begin
					rd = cmp_q[cmp_idx];
				end else begin
					acc = ACC_BAD_OFFSET;
				end
			end
			OP_WRITE: begin
				if (item.word == WORD_STATUS) begin
					if (item.data[STATUS_BIT_ONE])   flags_d[0] = 1'b0;
					if (item.data[STATUS_BIT_THREE]) flags_d[1] = 1'b0;
				end else if (item.word == WORD_COUNT_LO || item.word == WORD_COUNT_HI) begin
					acc = ACC_READ_ONLY;
				end else if (cmp_word) begin
					cmp_wr = 1'b1;
				end else begin
					acc = ACC_BAD_OFFSET;
				end
			end
			default: begin
				// Unused operation code: acts as idle.
			end
		endcase
	end

	assign result.read_data         = rd;
	assign result.access_status     = acc;
	assign result.irq_channel_one   = flags_d[0];
	assign result.irq_channel_three = flags_d[1];

	// State update once per item, as the item leaves the input stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			flags_q <= '0;
			for (int i = 0; i < NUM_CMP; i++) cmp_q[i] <= '0;
		end else if (step_en) begin
			flags_q <= flags_d;
			if (item.op == OP_TICK) count_q <= count_inc;
			if (cmp_wr) cmp_q[cmp_idx] <= item.data;
		end
	end

	// A tick never clears a flag.
	a_tick_keeps_flags: assert property (@(posedge clk) disable iff (!arst_n)
		step_en && item.op == OP_TICK |=> (flags_q & $past(flags_q)) == $past(flags_q))
		else $error("tick cleared a match flag");

	// Only an accepted tick moves the counter.
	a_count_only_on_tick: assert property (@(posedge clk) disable iff (!arst_n)
		!(step_en && item.op == OP_TICK) |=> count_q == $past(count_q))
		else $error("counter moved without a tick");

	// Any error status comes with zero read data.
	a_err_zero_data: assert property (@(posedge clk) disable iff (!arst_n)
		acc != ACC_OK |-> rd == '0)
		else $error("nonzero read data with error status");

	// The reserved status code is never produced.
	a_no_reserved_acc: assert property (@(posedge clk) disable iff (!arst_n)
		acc != ACC_RESERVED)
		else $error("reserved access status produced");

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for system_timer_compare_match: directed and random
// items, each result checked against a cycle-free prediction of the timer.
// Depends on stcm_pkg and the system_timer_compare_match RTL.
module tb;
	import stcm_pkg::*;

	// Compare channels that raise a match flag.
	localparam int CH_ONE = 1;
	localparam int CH_THREE = 3;
	// Length of the forced receiver hold-off, in cycles.
	localparam int HOLD_CYCLES = 64;
	// Cycles with no item moving on either side before the run is abandoned.
	localparam int QUIET_LIMIT = 1000;
	// Cycles to let pass after the last result before finishing.
	localparam int DRAIN_CYCLES = 8;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [IN_TDATA_W-1:0] s_axis_tdata = '0;
	logic [1:0] s_axis_tuser = OP_IDLE;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_axis_tdata;

	// Timer state as the testbench expects it.
	logic [COUNT_W-1:0] timer_count;
	logic [1:0] match_flags;
	logic [DATA_W-1:0] compare_regs [NUM_CMP];

	stcm_result_t timer_replies [$];
	int mismatch_count = 0;
	int items_sent = 0;
	int quiet_cycles = 0;
	int holds_requested = 0;
	bit idle_on = 1'b0;

	system_timer_compare_match dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

	always #10 clk = ~clk;

	// Advance the expected timer state by one item and return its result.
	function automatic stcm_result_t timer_step(logic [1:0] op, logic [2:0] word,
			logic [DATA_W-1:0] data);
		stcm_result_t res;
		res = '0;
		res.access_status = ACC_OK;
		case (op)
			OP_TICK: begin
				timer_count = timer_count + 1'b1;
				if (timer_count[DATA_W-1:0] == compare_regs[CH_ONE])
					match_flags[0] = 1'b1;
				if (timer_count[DATA_W-1:0] == compare_regs[CH_THREE])
					match_flags[1] = 1'b1;
			end
			OP_READ: begin
				case (word)
					WORD_STATUS: begin
						res.read_data[STATUS_BIT_ONE] = match_flags[0];
						res.read_data[STATUS_BIT_THREE] = match_flags[1];
					end
					WORD_COUNT_LO: res.read_data = timer_count[DATA_W-1:0];
					WORD_COUNT_HI: res.read_data = timer_count[COUNT_W-1:DATA_W];
					WORD_CMP0, WORD_CMP1, WORD_CMP2, WORD_CMP3: begin
						res.read_data = compare_regs[2'(word - WORD_CMP0)];
					end
					default: res.access_status = ACC_BAD_OFFSET;
				endcase
			end
			OP_WRITE: begin
				case (word)
					WORD_STATUS: begin
						if (data[STATUS_BIT_ONE])
							match_flags[0] = 1'b0;
						if (data[STATUS_BIT_THREE])
							match_flags[1] = 1'b0;
					end
					WORD_COUNT_LO, WORD_COUNT_HI: res.access_status = ACC_READ_ONLY;
					WORD_CMP0, WORD_CMP1, WORD_CMP2, WORD_CMP3: begin
						compare_regs[2'(word - WORD_CMP0)] = data;
					end
					default: res.access_status = ACC_BAD_OFFSET;
				endcase
			end
			default: ;
		endcase
		res.irq_channel_one = match_flags[0];
		res.irq_channel_three = match_flags[1];
		return res;
	endfunction

	// Offer one item, wait until it is taken, and record its expected result.
	task automatic send_item(logic [1:0] op, logic [2:0] word, logic [DATA_W-1:0] data);
		while (idle_on && $urandom_range(99) < 9) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata <= IN_TDATA_W'({$urandom, $urandom});
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= op;
		s_axis_tdata <= {{(IN_TDATA_W - DATA_W - 3){1'b0}}, data, word};
		do
			@(posedge clk);
		while (!s_axis_tready);
		timer_replies.push_back(timer_step(op, word, data));
		items_sent++;
	endtask

	task automatic report_field(string name, logic [DATA_W-1:0] want, logic [DATA_W-1:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
			mismatch_count++;
		end
	endtask

	// Check every result that leaves the block against the oldest expectation.
	always @(posedge clk) begin
		stcm_result_t got;
		stcm_result_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got = stcm_result_t'(m_axis_tdata[$bits(stcm_result_t)-1:0]);
			if (timer_replies.size() == 0) begin
				$display("%0t: unexpected result, expected none, actual %h", $time, got);
				mismatch_count++;
			end else begin
				want = timer_replies.pop_front();
				report_field("read_data", want.read_data, got.read_data);
				report_field("irq_channel_one", DATA_W'(want.irq_channel_one),
					DATA_W'(got.irq_channel_one));
				report_field("irq_channel_three", DATA_W'(want.irq_channel_three),
					DATA_W'(got.irq_channel_three));
				report_field("access_status", DATA_W'(want.access_status),
					DATA_W'(got.access_status));
			end
		end
	end

	// Receiver: random stalls, and a long hold-off whenever one is requested.
	initial begin : receiver
		int hold_left;
		int holds_served;
		hold_left = 0;
		holds_served = 0;
		forever begin
			@(posedge clk);
			if (hold_left > 0) begin
				hold_left--;
				m_axis_tready <= 1'b0;
			end else if (holds_served != holds_requested) begin
				holds_served++;
				hold_left = HOLD_CYCLES - 1;
				m_axis_tready <= 1'b0;
			end else if (idle_on) begin
				m_axis_tready <= ($urandom_range(99) >= 9);
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	// Give up when nothing moves on either side for too long.
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("%0t: no progress for %0d cycles", $time, QUIET_LIMIT);
			$display("status: fail");
			$finish;
		end
	end

	// Every register reads back as zero after reset, and the invalid word errs.
	task automatic test_reset_readback();
		for (int w = WORD_STATUS; w <= WORD_INVALID; w++)
			send_item(OP_READ, 3'(w), 32'hffff_ffff);
	endtask

	// Channels one and three match on the tick that reaches their value.
	task automatic test_compare_match();
		send_item(OP_WRITE, WORD_CMP1, 32'd2);
		send_item(OP_WRITE, WORD_CMP3, 32'd4);
		repeat (4) send_item(OP_TICK, WORD_STATUS, 32'd0);
		send_item(OP_READ, WORD_STATUS, 32'd0);
		// Only bit one clears channel one; other set bits are ignored.
		send_item(OP_WRITE, WORD_STATUS, 32'h0000_0002);
		send_item(OP_WRITE, WORD_STATUS, 32'hffff_fff5);
		send_item(OP_WRITE, WORD_STATUS, 32'hffff_ffff);
		// A compare value equal to the current count does not match by itself.
		send_item(OP_WRITE, WORD_CMP1, 32'd4);
		send_item(OP_TICK, WORD_INVALID, 32'hffff_ffff);
		send_item(OP_READ, WORD_STATUS, 32'd0);
	endtask

	// Counter writes, bad offsets and the unused operation code.
	task automatic test_access_errors();
		send_item(OP_WRITE, WORD_COUNT_LO, 32'hffff_ffff);
		send_item(OP_WRITE, WORD_COUNT_HI, 32'hffff_ffff);
		send_item(OP_WRITE, WORD_INVALID, 32'hffff_ffff);
		send_item(OP_IDLE, WORD_CMP2, 32'hffff_ffff);
		send_item(OP_WRITE, WORD_CMP0, 32'hffff_ffff);
		send_item(OP_READ, WORD_COUNT_LO, 32'd0);
	endtask

	// Arm a channel up to six ticks ahead, tick up to eight times, read the flags and sometimes write them.
	task automatic run_match_sequence();
		logic [2:0] armed;
		int ticks;
		armed = $urandom_range(1) ? WORD_CMP1 : WORD_CMP3;
		send_item(OP_WRITE, armed, timer_count[DATA_W-1:0] + $urandom_range(6));
		if ($urandom_range(3) == 0) begin
			send_item(OP_WRITE, (armed == WORD_CMP1) ? WORD_CMP3 : WORD_CMP1,
				timer_count[DATA_W-1:0] + $urandom_range(6));
		end
		ticks = $urandom_range(8);
		repeat (ticks) begin
			send_item(OP_TICK, 3'($urandom), $urandom);
			if ($urandom_range(4) == 0)
				send_item(OP_READ, 3'($urandom_range(WORD_CMP3)), $urandom);
		end
		send_item(OP_READ, WORD_STATUS, $urandom);
		if ($urandom_range(2) != 0)
			send_item(OP_WRITE, WORD_STATUS, $urandom);
	endtask

	// Mostly well-formed match sequences, the rest arbitrary items.
	task automatic test_random_traffic(int item_target, bit with_idling);
		idle_on = with_idling;
		while (items_sent < item_target) begin
			if ($urandom_range(9) < 7)
				run_match_sequence();
			else
				send_item(2'($urandom), 3'($urandom), $urandom);
		end
	endtask

	// Hold the receiver off while items keep coming, so the input stalls.
	task automatic test_backpressure();
		idle_on = 1'b0;
		holds_requested++;
		repeat (30) send_item(2'($urandom_range(OP_READ)), 3'($urandom), $urandom);
	endtask

	initial begin
		timer_count = '0;
		match_flags = '0;
		for (int i = 0; i < NUM_CMP; i++)
			compare_regs[i] = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_readback();
		test_compare_match();
		test_access_errors();
		test_backpressure();
		test_random_traffic(550, 1'b1);
		test_random_traffic(850, 1'b0);
		test_backpressure();
		test_random_traffic(1450, 1'b1);

		s_axis_tvalid <= 1'b0;
		while (timer_replies.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && timer_replies.size() == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule
